@@ hdl/ptb_pkg.sv @@
// Shared types, field codes and constants for the periodic timer bank.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package ptb_pkg;

    // Field widths fixed by the item formats.
    localparam int SLOT_W      = 4;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TIME_W      = 32;
    localparam int COOKIE_W    = 32;
    localparam int TICK_W      = 10;

    // Slot count defaults; the slot fields limit the active slots to sixteen.
    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_ACTIVE     = 16;

    // Reset value of the tick period register.
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = TICK_W'(1);

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] REPLY_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] REPLY_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] REPLY_FIRED  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 2'd3;

    // One input item.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   interval;
        logic                handler_present;
        logic [COOKIE_W-1:0] cookie;
        logic [SLOT_W-1:0]   slot;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]   reply_kind;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [COOKIE_W-1:0] fired_cookie;
        logic                last;
    } t_out_item;

    // One entry of the slot memory.
    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   period;
        logic [COOKIE_W-1:0] cookie;
    } t_slot_entry;

    // A result handed from the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

    // Builds a result item from its fields.
    function automatic t_out_item make_out(
        input logic [KIND_W-1:0]   reply_kind,
        input logic [STATUS_W-1:0] status,
        input logic [SLOT_W-1:0]   slot_index,
        input logic [COOKIE_W-1:0] fired_cookie,
        input logic                last
    );
        t_out_item r;
        r.reply_kind   = reply_kind;
        r.status       = status;
        r.slot_index   = slot_index;
        r.fired_cookie = fired_cookie;
        r.last         = last;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/periodic_timer_bank_core.sv @@
// Top level of the periodic timer bank: tick period register, sequencer,
// slot memory and output register. Depends on ptb_pkg and the ptb_* modules.
//
//   Channel   Direction  Handshake                    Payload
//   cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_data (tick period, ms)
//   in        in         i_in_valid  / o_in_ready     i_in  (t_in_item)
//   out       out        o_out_valid / i_out_ready    o_out (t_out_item)
//
// A tick is accepted and the next item can follow at once; a create or free
// passes through the flush state before the next item is accepted, and its reply then sits in the output register.
// A poll reads the slot memory once per active slot (at most 16) through its
// single registered read port, then flushes its final result.
// The scan holds on a slot while a second result waits for a full output register,
// and the flush holds until its result is taken. Reset is synchronous and active low; it clears the time counter
// and the slot-in-use flags, and the slot memory needs no clearing pass.
`default_nettype none

module periodic_timer_bank_core
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [TICK_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out
);

    localparam int ActiveSlots = (NUM_TIMERS < MAX_ACTIVE) ? NUM_TIMERS : MAX_ACTIVE;
    localparam int AddrW       = (ActiveSlots > 1) ? $clog2(ActiveSlots) : 1;

    logic [TICK_W-1:0] r_tick_period;
    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    t_slot_entry       mem_wdata;
    logic              mem_re;
    logic [AddrW-1:0]  mem_raddr;
    t_slot_entry       mem_rdata;
    t_push             push;
    logic              can_push;

    // Tick period register; every transfer on the configuration channel writes it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
        end else if (i_cfg_valid) begin
            r_tick_period <= i_cfg_data;
        end
    end

    // Sequencer.
    ptb_ctrl #(
        .ACTIVE_SLOTS (ActiveSlots),
        .ADDR_W       (AddrW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_period (r_tick_period),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .o_push        (push),
        .i_can_push    (can_push)
    );

    // Slot memory.
    ptb_slot_mem #(
        .DEPTH  (ActiveSlots),
        .ADDR_W (AddrW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register.
    ptb_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_can_push  (can_push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ hdl/ptb_slot_mem.sv @@
// Slot memory of the timer bank: start time, period and cookie of each slot.
// One write port and one registered read port; uses types from ptb_pkg.
`default_nettype none

module ptb_slot_mem
    import ptb_pkg::*;
#(
    parameter int DEPTH  = NUM_TIMERS_DEF,
    parameter int ADDR_W = SLOT_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_slot_entry       i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_slot_entry            o_rdata
);

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    // Write port; entries are undefined until a create writes them.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/ptb_out_stage.sv @@
// Output register of the timer bank, which parts the sequencer from the consumer.
// Uses the item and transfer types from ptb_pkg.
`default_nettype none

module ptb_out_stage
    import ptb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_can_push,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_item  o_out
);

    logic      r_valid;
    t_out_item r_item;

    // The register takes a new result when it is empty or is being emptied.
    assign o_can_push = !r_valid || i_out_ready;

    // Valid flag: set by a push, cleared by a completed transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload is loaded only on a push, so it holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_item <= i_push.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_item;

endmodule

`default_nettype wire

@@ hdl/ptb_ctrl.sv @@
// Sequencer of the timer bank: time counter, slot-in-use flags, item decoding
// and the poll scan over the slot memory. Uses types and codes from ptb_pkg.
`default_nettype none

module ptb_ctrl
    import ptb_pkg::*;
#(
    parameter int ACTIVE_SLOTS = MAX_ACTIVE,
    parameter int ADDR_W       = SLOT_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TICK_W-1:0] i_tick_period,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    output logic                   o_mem_we,
    output logic [ADDR_W-1:0]      o_mem_waddr,
    output t_slot_entry            o_mem_wdata,
    output logic                   o_mem_re,
    output logic [ADDR_W-1:0]      o_mem_raddr,
    input  wire t_slot_entry       i_mem_rdata,
    output t_push                  o_push,
    input  wire logic              i_can_push
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [TIME_W-1:0]        r_now, n_now;
    logic [ACTIVE_SLOTS-1:0]  r_used, n_used;
    logic [ADDR_W-1:0]        r_idx, n_idx;
    logic                     r_pend_valid, n_pend_valid;
    t_out_item                r_pend, n_pend;

    logic                     free_found;
    logic [ADDR_W-1:0]        free_idx;
    logic [TIME_W-1:0]        elapsed;
    logic                     fire;
    logic                     req_in_range;
    logic                     req_used;
    logic                     create_bad;
    logic                     last_slot;

    // Lowest-numbered free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = ADDR_W'(i);
            end
        end
    end

    // Expiry of the slot whose entry the memory is presenting.
    assign elapsed   = r_now - i_mem_rdata.start;
    assign fire      = r_used[r_idx] && (elapsed >= i_mem_rdata.period);
    assign last_slot = (r_idx == ADDR_W'(ACTIVE_SLOTS - 1));

    // Checks on create and free items.
    assign create_bad   = (i_in.interval == '0) || !i_in.handler_present;
    assign req_in_range = ({1'b0, i_in.slot} < (SLOT_W + 1)'(ACTIVE_SLOTS));
    assign req_used     = req_in_range && r_used[i_in.slot[ADDR_W-1:0]];

    assign o_in_ready = (r_state == S_IDLE);

    // Next-state logic. A fired result waits in the pending register until the
    // next one fires or the scan ends, so that the final one can be marked last.
    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_used       = r_used;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_idx;
        o_mem_wdata  = '{start: r_now, period: i_mem_rdata.period,
                         cookie: i_mem_rdata.cookie};
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_idx + ADDR_W'(1);
        o_push.valid = 1'b0;
        o_push.item  = r_pend;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.kind)
                        KIND_TICK: begin
                            n_now = r_now + TIME_W'(i_tick_period);
                        end
                        KIND_POLL: begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = '0;
                            n_idx       = '0;
                            n_state     = S_SCAN;
                        end
                        KIND_CREATE: begin
                            n_pend_valid = 1'b1;
                            n_state      = S_FLUSH;
                            if (create_bad) begin
                                n_pend = make_out(REPLY_CREATE, ST_INVALID, '0, '0, 1'b1);
                            end else if (free_found) begin
                                o_mem_we         = 1'b1;
                                o_mem_waddr      = free_idx;
                                o_mem_wdata      = '{start: r_now, period: i_in.interval,
                                                     cookie: i_in.cookie};
                                n_used[free_idx] = 1'b1;
                                n_pend = make_out(REPLY_CREATE, ST_OK, SLOT_W'(free_idx),
                                                  '0, 1'b1);
                            end else begin
                                n_pend = make_out(REPLY_CREATE, ST_FULL, '0, '0, 1'b1);
                            end
                        end
                        default: begin
                            n_pend_valid = 1'b1;
                            n_state      = S_FLUSH;
                            if (req_used) begin
                                n_used[i_in.slot[ADDR_W-1:0]] = 1'b0;
                                n_pend = make_out(REPLY_FREE, ST_OK, i_in.slot, '0, 1'b1);
                            end else begin
                                n_pend = make_out(REPLY_FREE, ST_NOT_IN_USE, i_in.slot,
                                                  '0, 1'b1);
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Hold the slot when a second result must leave but the
                // output register is still occupied.
                if (!(fire && r_pend_valid && !i_can_push)) begin
                    if (fire) begin
                        o_mem_we     = 1'b1;
                        o_push.valid = r_pend_valid;
                        n_pend_valid = 1'b1;
                        n_pend = make_out(REPLY_FIRED, ST_OK, SLOT_W'(r_idx),
                                          i_mem_rdata.cookie, 1'b0);
                    end
                    if (last_slot) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_mem_re = 1'b1;
                        n_idx    = r_idx + ADDR_W'(1);
                    end
                end
            end

            S_FLUSH: begin
                // The pending result is the final one of its item.
                o_push.item.last = 1'b1;
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_can_push) begin
                    o_push.valid = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_used       <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_used       <= n_used;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Pending result payload.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

@@ hdl/ptb_checker.sv @@
// Port-level checks of the periodic timer bank, attached to the top level by bind.
// Depends on ptb_pkg and on periodic_timer_bank_core.
`default_nettype none

module ptb_checker
    import ptb_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out
);

    // A result that is not taken stays offered, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // Any item other than a tick keeps the input from being ready straight after it is taken.
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.kind != KIND_TICK |=> !o_in_ready)
        else $error("input accepted again straight after a non-tick transfer");

    // A tick only advances the counter, so the next item is taken at once.
    a_tick_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.kind == KIND_TICK |=> o_in_ready)
        else $error("input not ready after a tick");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind periodic_timer_bank_core ptb_checker u_ptb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

@@ sim/tb_periodic_timer_bank_core.sv @@
// Self-checking testbench for periodic_timer_bank_core: a stimulus table, then random traffic.
// Each accepted reply is checked against a local model of the timer bank or a reply typed in the table.
// Depends on ptb_pkg and the RTL of the block.
`default_nettype none

module tb_periodic_timer_bank_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int SLOTS          = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 32;
    localparam int NUM_PHASES     = 5;

    // One row of the stimulus table; a typed reply replaces the modelled one.
    typedef struct {
        t_in_item  item;
        int        reps;
        bit        typed;
        t_out_item reply;
    } t_stim_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [TICK_W-1:0] cfg_data    = '0;
    logic              in_valid    = 1'b0;
    t_in_item          in_data     = '0;
    logic              out_ready   = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out;

    // Local model of the timer bank.
    logic [TIME_W-1:0]   bank_now;
    logic [TIME_W-1:0]   bank_tick;
    bit                  bank_used   [SLOTS];
    logic [TIME_W-1:0]   bank_start  [SLOTS];
    logic [TIME_W-1:0]   bank_period [SLOTS];
    logic [COOKIE_W-1:0] bank_cookie [SLOTS];

    t_out_item expected_replies[$];
    t_stim_row stim_table[$];
    int        n_errors    = 0;
    int        cycle_count = 0;
    int        send_pct    = 0;
    int        recv_pct    = 0;

    periodic_timer_bank_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    // Clock with an 8 ns period.
    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Applies one item to the model and returns the replies that it causes.
    function automatic void advance_timer_bank(input t_in_item it, ref t_out_item res[$]);
        logic [TIME_W-1:0] elapsed;
        bit                placed;
        res.delete();
        case (it.kind)
            KIND_TICK: begin
                bank_now = bank_now + bank_tick;
            end
            KIND_POLL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    elapsed = bank_now - bank_start[i];
                    if (bank_used[i] && elapsed >= bank_period[i]) begin
                        bank_start[i] = bank_now;
                        res.push_back(t_out_item'{REPLY_FIRED, ST_OK, SLOT_W'(i),
                                                  bank_cookie[i], 1'b0});
                    end
                end
                if (res.size() > 0) res[res.size()-1].last = 1'b1;
            end
            KIND_CREATE: begin
                placed = 1'b0;
                if (it.interval == '0 || !it.handler_present) begin
                    res.push_back(t_out_item'{REPLY_CREATE, ST_INVALID, '0, '0, 1'b1});
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!placed && !bank_used[i]) begin
                            placed         = 1'b1;
                            bank_used[i]   = 1'b1;
                            bank_start[i]  = bank_now;
                            bank_period[i] = it.interval;
                            bank_cookie[i] = it.cookie;
                            res.push_back(t_out_item'{REPLY_CREATE, ST_OK, SLOT_W'(i),
                                                      '0, 1'b1});
                        end
                    end
                    if (!placed)
                        res.push_back(t_out_item'{REPLY_CREATE, ST_FULL, '0, '0, 1'b1});
                end
            end
            default: begin
                if (bank_used[it.slot]) begin
                    bank_used[it.slot] = 1'b0;
                    res.push_back(t_out_item'{REPLY_FREE, ST_OK, it.slot, '0, 1'b1});
                end else begin
                    res.push_back(t_out_item'{REPLY_FREE, ST_NOT_IN_USE, it.slot, '0, 1'b1});
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Reply side: check every transfer and stall at random.
    always @(posedge i_clk) begin : reply_side
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_replies.size() == 0) begin
                $error("reply with nothing expected: kind %0h slot %0h",
                       o_out.reply_kind, o_out.slot_index);
                n_errors++;
            end else begin
                want = expected_replies.pop_front();
                check_field("reply_kind", 32'(want.reply_kind), 32'(o_out.reply_kind));
                check_field("status", 32'(want.status), 32'(o_out.status));
                check_field("slot_index", 32'(want.slot_index), 32'(o_out.slot_index));
                check_field("fired_cookie", want.fired_cookie, o_out.fired_cookie);
                check_field("last", 32'(want.last), 32'(o_out.last));
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // Offers one item, waits for its transfer and records the replies it causes.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item reply);
        t_out_item modelled[$];
        if ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        advance_timer_bank(it, modelled);
        if (typed) expected_replies.push_back(reply);
        else foreach (modelled[k]) expected_replies.push_back(modelled[k]);
    endtask

    // Lowers valid and waits until every reply is in and the block has settled.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tick_period(input logic [TICK_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        bank_tick = TIME_W'(value);
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] period,
                           input logic handler, input logic [COOKIE_W-1:0] cookie,
                           input logic [SLOT_W-1:0] slot, input int reps,
                           input bit typed, input t_out_item reply);
        t_stim_row row;
        row.item  = t_in_item'{kind, period, handler, cookie, slot};
        row.reps  = reps;
        row.typed = typed;
        row.reply = reply;
        stim_table.push_back(row);
    endtask

    // Random item: ticks, polls, mostly well-formed creates, and frees mostly of slots in use.
    function automatic t_in_item random_item();
        t_in_item          it;
        int                used_slots[$];
        int                sel;
        logic [TIME_W-1:0] unit;
        it.kind            = KIND_TICK;
        it.interval        = $urandom;
        it.handler_present = 1'($urandom_range(0, 1));
        it.cookie          = $urandom;
        it.slot            = SLOT_W'($urandom_range(0, SLOTS - 1));
        unit               = (bank_tick == '0) ? TIME_W'(1) : bank_tick;
        sel                = $urandom_range(0, 99);
        if (sel < 35) begin
            it.kind = KIND_TICK;
        end else if (sel < 60) begin
            it.kind = KIND_POLL;
        end else if (sel < 85) begin
            it.kind = KIND_CREATE;
            sel     = $urandom_range(0, 99);
            if (sel < 80) begin
                it.handler_present = 1'b1;
                it.interval        = $urandom_range(1, 6 * unit);
            end else if (sel < 88) begin
                it.handler_present = 1'b1;
            end else if (sel < 94) begin
                it.interval = '0;
            end else begin
                it.handler_present = 1'b0;
            end
        end else begin
            it.kind = KIND_FREE;
            for (int i = 0; i < SLOTS; i++) if (bank_used[i]) used_slots.push_back(i);
            if (used_slots.size() > 0 && $urandom_range(0, 99) < 70)
                it.slot = SLOT_W'(used_slots[$urandom_range(0, used_slots.size() - 1)]);
        end
        return it;
    endfunction

    // Main sequence: reset, stimulus table, then random phases.
    initial begin : main_sequence
        logic [TICK_W-1:0] tick_plan [NUM_PHASES];
        int                send_plan [NUM_PHASES];
        int                recv_plan [NUM_PHASES];
        bank_now  = '0;
        bank_tick = TIME_W'(TICK_PERIOD_RST);
        for (int i = 0; i < SLOTS; i++) begin
            bank_used[i]   = 1'b0;
            bank_start[i]  = '0;
            bank_period[i] = '0;
            bank_cookie[i] = '0;
        end
        tick_plan = '{TICK_W'(1000), TICK_W'(0), TICK_W'(1023),
                      TICK_W'($urandom_range(2, 20)), TICK_W'(1)};
        send_plan = '{0, 45, 0, 14, 0};
        recv_plan = '{0, 0, 45, 14, 0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Frees of unused slots, rejected creates, creates at the extremes, then polls, a tick and frees.
        add_row(KIND_FREE, '0, 1'b0, '0, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_FREE, ST_NOT_IN_USE, 4'd0, '0, 1'b1});
        add_row(KIND_FREE, '1, 1'b1, '1, 4'd15, 1, 1'b1,
                t_out_item'{REPLY_FREE, ST_NOT_IN_USE, 4'd15, '0, 1'b1});
        add_row(KIND_POLL, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);
        add_row(KIND_CREATE, '0, 1'b1, 32'h1234_5678, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_INVALID, 4'd0, '0, 1'b1});
        add_row(KIND_CREATE, '1, 1'b0, '1, 4'd9, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_INVALID, 4'd0, '0, 1'b1});
        add_row(KIND_CREATE, 32'd1, 1'b1, '1, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_OK, 4'd0, '0, 1'b1});
        add_row(KIND_CREATE, '1, 1'b1, '0, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_OK, 4'd1, '0, 1'b1});
        add_row(KIND_POLL, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);
        add_row(KIND_TICK, '1, 1'b1, '1, 4'd15, 1, 1'b0, '0);
        add_row(KIND_POLL, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);
        add_row(KIND_FREE, '0, 1'b0, '0, 4'd1, 1, 1'b1,
                t_out_item'{REPLY_FREE, ST_OK, 4'd1, '0, 1'b1});
        add_row(KIND_FREE, '0, 1'b0, '0, 4'd1, 1, 1'b1,
                t_out_item'{REPLY_FREE, ST_NOT_IN_USE, 4'd1, '0, 1'b1});
        // Fill the bank, then a create when full and an invalid one when full.
        add_row(KIND_CREATE, 32'd3, 1'b1, 32'hA5A5_5A5A, 4'd0, 15, 1'b0, '0);
        add_row(KIND_CREATE, 32'd2, 1'b1, 32'h0F0F_F0F0, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_FULL, 4'd0, '0, 1'b1});
        add_row(KIND_CREATE, '0, 1'b1, 32'h0F0F_F0F0, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_INVALID, 4'd0, '0, 1'b1});
        // Let every slot expire in a single poll, the longest burst of results.
        add_row(KIND_TICK, '0, 1'b0, '0, 4'd0, 3, 1'b0, '0);
        add_row(KIND_POLL, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);
        add_row(KIND_FREE, '0, 1'b0, '0, 4'd7, 1, 1'b1,
                t_out_item'{REPLY_FREE, ST_OK, 4'd7, '0, 1'b1});
        add_row(KIND_CREATE, 32'd1, 1'b1, 32'hDEAD_BEEF, 4'd0, 1, 1'b1,
                t_out_item'{REPLY_CREATE, ST_OK, 4'd7, '0, 1'b1});
        add_row(KIND_TICK, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);
        add_row(KIND_POLL, '0, 1'b0, '0, 4'd0, 1, 1'b0, '0);

        foreach (stim_table[r])
            repeat (stim_table[r].reps)
                send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].reply);
        wait_drained();

        // Random phases, each with its own tick period and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_tick_period(tick_plan[p]);
            send_pct = send_plan[p];
            recv_pct = recv_plan[p];
            repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
            wait_drained();
        end

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
